// ----- sv/nbt_pkg.sv -----
package nbt_pkg;

    localparam int MAX_BLOBS  = 32;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_BLOBS);
    localparam int CNT_W      = $clog2(MAX_BLOBS + 1);

    localparam logic [12:0] ACT_CAP    = 13'd5120;
    localparam logic [10:0] SPEED_GAIN = 11'd2000;

    // Widths derived from the coordinate size; the root operand is kept at an
    // even width so its bits pair up from the least significant end
    localparam int D2_W  = 2 * COORD_BITS + 1;
    localparam int RAD_W = D2_W + 17;
    localparam int LEN_W = (RAD_W + 1) / 2;
    localparam int DIV_N = LEN_W + 11;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_MATCH = 2'd1;
    localparam logic [1:0] MODE_ADD   = 2'd2;
    localparam logic [1:0] MODE_END   = 2'd3;

    localparam logic [1:0] REG_DEATH  = 2'd0;
    localparam logic [1:0] REG_MAXD   = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;
    localparam logic [1:0] REG_DECAY  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] center_x;
        logic [11:0] center_y;
        logic [19:0] blob_area;
        logic [31:0] time_ms;
    } in_item_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] blob_id;
        logic [12:0] activity_level;
        logic [5:0]  live_count;
        logic        table_full;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_req_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_clear;
        logic scan_step;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start;
        logic div_step;
        logic mul_step;
        logic commit;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] mode;
        logic       scan_last;
        logic       found;
        logic       sqrt_last;
        logic       div_last;
    } dp_stat_t;

endpackage

// ----- sv/nbt_datapath.sv -----
module nbt_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  nbt_pkg::in_item_t in_item,
    input  logic              cfg_we,
    input  nbt_pkg::cfg_req_t cfg_req,
    input  nbt_pkg::dp_cmd_t  cmd,
    output nbt_pkg::dp_stat_t stat,
    output nbt_pkg::out_item_t result
);
    import nbt_pkg::*;

    logic [15:0] death_reg;
    logic [11:0] maxd_reg;
    logic [23:0] thresh_reg;
    logic [16:0] decay_reg;

    logic [MAX_BLOBS-1:0] valid_reg, valid_next;
    logic [MAX_BLOBS-1:0] asg_reg, asg_next;
    logic [15:0] id_arr [MAX_BLOBS];
    logic [COORD_BITS-1:0] x_arr [MAX_BLOBS];
    logic [COORD_BITS-1:0] y_arr [MAX_BLOBS];
    logic [19:0] area_arr [MAX_BLOBS];
    logic [12:0] act_arr [MAX_BLOBS];
    logic [31:0] alive_arr [MAX_BLOBS];
    logic [15:0] next_id_reg;

    in_item_t item_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic             found_reg;
    logic [D2_W-1:0]  best_d2_reg;
    logic [D2_W-1:0]  lim_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             free_ok_reg;

    // Square root by digit recurrence, one result bit per step
    logic [RAD_W-1:0] sq_rem_reg;
    logic [RAD_W-1:0] sq_v_reg;
    logic [LEN_W-1:0] sq_res_reg;
    logic [$clog2(LEN_W+1)-1:0] sq_cnt_reg;

    // Restoring divider, one quotient bit per step
    logic [DIV_N-1:0] dv_q_reg;
    logic [20:0]      dv_rem_reg;
    logic [20:0]      dv_den_reg;
    logic [$clog2(DIV_N+1)-1:0] dv_cnt_reg;

    logic [12:0] decayed_reg;
    out_item_t   result_reg;
    out_item_t   result_next;

    // Scan datapath: distance of the current entry
    logic [COORD_BITS-1:0] cx, cy, dx, dy;
    logic [D2_W-1:0] d2;
    logic            cand;
    assign cx = item_reg.center_x[COORD_BITS-1:0];
    assign cy = item_reg.center_y[COORD_BITS-1:0];
    assign dx = (cx > x_arr[idx_reg]) ? cx - x_arr[idx_reg] : x_arr[idx_reg] - cx;
    assign dy = (cy > y_arr[idx_reg]) ? cy - y_arr[idx_reg] : y_arr[idx_reg] - cy;
    assign d2 = D2_W'(dx * dx) + D2_W'(dy * dy);
    assign cand = valid_reg[idx_reg] && !asg_reg[idx_reg] && (d2 < lim_reg);

    logic better;
    assign better = !found_reg || (d2 < best_d2_reg) ||
                    (d2 == best_d2_reg && id_arr[idx_reg] < id_arr[best_idx_reg]);

    // Sqrt step
    logic [RAD_W+1:0] sq_trial;
    logic [RAD_W+1:0] sq_rem_sh;
    assign sq_rem_sh = {sq_rem_reg, sq_v_reg[RAD_W-1 -: 2]};
    assign sq_trial  = (RAD_W+2)'({sq_res_reg, 2'b01});

    // Divider step
    logic [21:0] dv_sh;
    assign dv_sh = {dv_rem_reg, dv_q_reg[DIV_N-1]};

    // Final activity
    logic [DIV_N-1:0] act_raw;
    logic [DIV_N-1:0] speed;
    logic [DIV_N:0]   act_sum;
    logic [12:0]      act_fin;
    assign act_raw = dv_q_reg;
    assign speed   = (act_raw > DIV_N'(thresh_reg)) ? act_raw - DIV_N'(thresh_reg) : '0;
    assign act_sum = (DIV_N+1)'(decayed_reg) + (DIV_N+1)'(speed);
    assign act_fin = (act_sum > (DIV_N+1)'(ACT_CAP)) ? ACT_CAP : act_sum[12:0];

    logic [29:0] mul_prod;
    assign mul_prod = act_arr[best_idx_reg] * decay_reg;

    logic [CNT_W-1:0] live_cnt;
    always_comb
    begin
        live_cnt = '0;
        for (int i = 0; i < MAX_BLOBS; i++)
            live_cnt = live_cnt + CNT_W'(valid_next[i]);
    end

    // Frame end aging of the current entry
    logic stale;
    assign stale = (item_reg.time_ms - alive_arr[idx_reg]) > {16'd0, death_reg};

    // Next table marks
    always_comb
    begin
        valid_next = valid_reg;
        asg_next   = asg_reg;
        if (cmd.commit)
        begin
            case (item_reg.mode)
                MODE_START: asg_next = '0;
                MODE_MATCH:
                begin
                    if (found_reg)
                        asg_next[best_idx_reg] = 1'b1;
                end
                MODE_ADD:
                begin
                    if (free_ok_reg)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                        asg_next[free_idx_reg]   = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.scan_step && item_reg.mode == MODE_END && valid_reg[idx_reg] &&
            !asg_reg[idx_reg] && stale)
            valid_next[idx_reg] = 1'b0;
    end

    // Build the result of the request being committed
    always_comb
    begin
        result_next            = '0;
        result_next.live_count = 6'(live_cnt);
        case (item_reg.mode)
            MODE_MATCH:
            begin
                if (found_reg)
                begin
                    result_next.matched        = 1'b1;
                    result_next.blob_id        = id_arr[best_idx_reg];
                    result_next.activity_level = act_fin;
                end
            end
            MODE_ADD:
            begin
                if (free_ok_reg)
                begin
                    result_next.matched        = 1'b1;
                    result_next.blob_id        = next_id_reg;
                    result_next.activity_level = ACT_CAP;
                end
                else
                    result_next.table_full = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            death_reg   <= 16'd500;
            maxd_reg    <= 12'd100;
            thresh_reg  <= '0;
            decay_reg   <= 17'd65536;
            valid_reg   <= '0;
            asg_reg     <= '0;
            next_id_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_req.index)
                    REG_DEATH:  death_reg  <= cfg_req.data[15:0];
                    REG_MAXD:   maxd_reg   <= cfg_req.data[11:0];
                    REG_THRESH: thresh_reg <= cfg_req.data[23:0];
                    REG_DECAY:  decay_reg  <= cfg_req.data[16:0];
                    default: ;
                endcase
            end
            valid_reg <= valid_next;
            asg_reg   <= asg_next;
            if (cmd.commit && item_reg.mode == MODE_ADD && free_ok_reg)
                next_id_reg <= next_id_reg + 16'd1;
            if (cmd.commit && item_reg.mode == MODE_END && valid_reg == '0)
                next_id_reg <= '0;
        end
    end

    // Entry payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            lim_reg  <= D2_W'(maxd_reg * maxd_reg);
        end
        if (cmd.scan_clear)
        begin
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
            if (item_reg.mode == MODE_MATCH && cand && better)
            begin
                found_reg    <= 1'b1;
                best_idx_reg <= idx_reg;
                best_d2_reg  <= d2;
            end
            if (!valid_reg[idx_reg] && !free_ok_reg)
            begin
                free_ok_reg  <= 1'b1;
                free_idx_reg <= idx_reg;
            end
            if (item_reg.mode == MODE_END && valid_reg[idx_reg] && asg_reg[idx_reg])
                alive_arr[idx_reg] <= item_reg.time_ms;
        end

        if (cmd.sqrt_start)
        begin
            sq_rem_reg <= '0;
            sq_res_reg <= '0;
            sq_v_reg   <= RAD_W'({best_d2_reg, 16'd0});
            sq_cnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_v_reg   <= sq_v_reg << 2;
            sq_cnt_reg <= sq_cnt_reg + ($clog2(LEN_W+1))'(1);
            if (sq_rem_sh >= sq_trial)
            begin
                sq_rem_reg <= RAD_W'(sq_rem_sh - sq_trial);
                sq_res_reg <= {sq_res_reg[LEN_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg <= RAD_W'(sq_rem_sh);
                sq_res_reg <= {sq_res_reg[LEN_W-2:0], 1'b0};
            end
        end

        if (cmd.mul_step)
            decayed_reg <= (act_arr[best_idx_reg] == '0) ? '0 :
                ((mul_prod[29:16] > 14'(ACT_CAP)) ? ACT_CAP : mul_prod[28:16]);

        if (cmd.div_start)
        begin
            dv_q_reg   <= DIV_N'(sq_res_reg * SPEED_GAIN);
            dv_rem_reg <= '0;
            dv_den_reg <= {1'b0, area_arr[best_idx_reg]} + 21'd1;
            dv_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dv_cnt_reg <= dv_cnt_reg + ($clog2(DIV_N+1))'(1);
            if (dv_sh >= {1'b0, dv_den_reg})
            begin
                dv_rem_reg <= 21'(dv_sh - {1'b0, dv_den_reg});
                dv_q_reg   <= {dv_q_reg[DIV_N-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_sh[20:0];
                dv_q_reg   <= {dv_q_reg[DIV_N-2:0], 1'b0};
            end
        end

        if (cmd.commit)
        begin
            result_reg <= result_next;
            case (item_reg.mode)
                MODE_MATCH:
                begin
                    if (found_reg)
                        act_arr[best_idx_reg] <= act_fin;
                end
                MODE_ADD:
                begin
                    if (free_ok_reg)
                    begin
                        id_arr[free_idx_reg]    <= next_id_reg;
                        x_arr[free_idx_reg]     <= cx;
                        y_arr[free_idx_reg]     <= cy;
                        area_arr[free_idx_reg]  <= item_reg.blob_area;
                        act_arr[free_idx_reg]   <= ACT_CAP;
                        alive_arr[free_idx_reg] <= item_reg.time_ms;
                    end
                end
                default: ;
            endcase
        end
    end

    assign stat.mode      = item_reg.mode;
    assign stat.scan_last = (idx_reg == IDX_W'(MAX_BLOBS - 1));
    assign stat.found     = found_reg;
    assign stat.sqrt_last = (sq_cnt_reg == ($clog2(LEN_W+1))'(LEN_W - 1));
    assign stat.div_last  = (dv_cnt_reg == ($clog2(DIV_N+1))'(DIV_N - 1));
    assign result         = result_reg;

`ifndef SYNTHESIS
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit) |-> result_reg.activity_level <= ACT_CAP)
        else $error("activity above cap");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit) |-> !(result_reg.matched && result_reg.table_full))
        else $error("matched and full together");
    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit) |-> result_reg.live_count == 6'($countones(valid_reg)))
        else $error("live count mismatch");
`endif

endmodule

// ----- sv/nbt_ctrl.sv -----
module nbt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  nbt_pkg::dp_stat_t stat,
    output nbt_pkg::dp_cmd_t  cmd
);
    import nbt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_SQRT  = 7'b0000100,
        S_DIVS  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    logic take;
    assign take = (state_reg == S_IDLE) && in_valid;
    assign in_stall = (state_reg != S_IDLE);

    // Sequence one request through scan, then root and divide for a match that hits, then commit
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    if (stat.mode == MODE_MATCH)
                        state_next = S_DONE;
                    else
                        state_next = S_OUT;
                end
            end
            S_DONE:
            begin
                if (stat.found)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
                else
                    state_next = S_OUT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                cmd.mul_step  = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the previous result has left the output register
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg) else $error("result not posted");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg) else $error("stalled result dropped");
    a_nooverwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");
`endif

endmodule

// ----- sv/nearest_blob_tracker_table.sv -----
// Centroid tracker over a 32-slot blob table. Each request (frame start, match,
// add, frame end) gives one result. Every request scans all slots one per cycle;
// a match that hits then runs a bit-serial square root and a restoring divider
// before its result is committed. A request is taken only while idle, so the
// next one waits until the current result has been committed to the output
// register. A new request may be taken while the previous result still waits in
// the output register; its own result is held back, adding stall cycles, until
// that one has left. Configuration must be written only while idle; the block
// itself does not enforce it.
module nearest_blob_tracker_table
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nbt_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nbt_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  nbt_pkg::cfg_req_t   cfg_data
);
    import nbt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    nbt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    nbt_datapath u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cfg_we  (cfg_valid & cfg_ready),
        .cfg_req (cfg_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );

endmodule

// ----- sim/nearest_blob_tracker_table_tb.sv -----
module nearest_blob_tracker_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nbt_pkg::*;

    localparam int SLOTS       = 32;
    localparam int RANDOM_REQS = 1350;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        in_item_t  req;
        logic      fixed;
        out_item_t want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_req_t   cfg_data = '0;

    // tracker model state
    logic [15:0] death_ms;
    logic [11:0] radius;
    logic [23:0] speed_floor;
    logic [16:0] decay_mult;
    bit          trk_valid [SLOTS];
    bit          trk_taken [SLOTS];
    logic [15:0] trk_id [SLOTS];
    logic [11:0] trk_x [SLOTS];
    logic [11:0] trk_y [SLOTS];
    logic [19:0] trk_area [SLOTS];
    logic [12:0] trk_act [SLOTS];
    logic [31:0] trk_seen [SLOTS];
    logic [15:0] id_counter;

    out_item_t   pending_results [$];
    int          error_count = 0;
    bit          steady = 1'b0;
    int          cycle_count = 0;
    logic [31:0] now_ms;
    stim_row_t   stim_rows [21];

    nearest_blob_tracker_table i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // give up on a hang
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 22; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [5:0] live_slots();
        logic [5:0] n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (trk_valid[i])
                n++;
        return n;
    endfunction

    function automatic void clear_tracker();
        death_ms    = 16'd500;
        radius      = 12'd100;
        speed_floor = 24'd0;
        decay_mult  = 17'd65536;
        for (int i = 0; i < SLOTS; i++)
        begin
            trk_valid[i] = 1'b0;
            trk_taken[i] = 1'b0;
        end
        id_counter = 16'd0;
    endfunction

    function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_DEATH:  death_ms    = val[15:0];
            REG_MAXD:   radius      = val[11:0];
            REG_THRESH: speed_floor = val[23:0];
            REG_DECAY:  decay_mult  = val[16:0];
            default: ;
        endcase
    endfunction

    // advance the tracker by one request and return its result
    function automatic out_item_t track_step(input in_item_t r);
        out_item_t       res;
        int              best_slot;
        longint unsigned best_d2;
        longint unsigned d2;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned lim;
        longint unsigned len_q8;
        longint unsigned act;
        longint unsigned speed;
        longint unsigned a;
        res = '0;
        best_slot = -1;
        best_d2 = 0;
        case (r.mode)
            MODE_START:
                for (int i = 0; i < SLOTS; i++)
                    trk_taken[i] = 1'b0;
            MODE_MATCH:
            begin
                lim = longint'(radius) * longint'(radius);
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!trk_valid[i] || trk_taken[i])
                        continue;
                    dx = (r.center_x > trk_x[i]) ? r.center_x - trk_x[i] : trk_x[i] - r.center_x;
                    dy = (r.center_y > trk_y[i]) ? r.center_y - trk_y[i] : trk_y[i] - r.center_y;
                    d2 = dx * dx + dy * dy;
                    if (d2 >= lim)
                        continue;
                    if (best_slot < 0 || d2 < best_d2 ||
                        (d2 == best_d2 && trk_id[i] < trk_id[best_slot]))
                    begin
                        best_d2 = d2;
                        best_slot = i;
                    end
                end
                if (best_slot >= 0)
                begin
                    len_q8 = floor_sqrt(best_d2 << 16);
                    act = (64'd2000 * len_q8) / (longint'(trk_area[best_slot]) + 1);
                    speed = (act > speed_floor) ? act - speed_floor : 0;
                    a = trk_act[best_slot];
                    if (a != 0)
                        a = (a * decay_mult) >> 16;
                    a += speed;
                    if (a > 5120)
                        a = 5120;
                    trk_act[best_slot] = a[12:0];
                    trk_taken[best_slot] = 1'b1;
                    res.matched = 1'b1;
                    res.blob_id = trk_id[best_slot];
                    res.activity_level = a[12:0];
                end
            end
            MODE_ADD:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (!trk_valid[i])
                    begin
                        best_slot = i;
                        break;
                    end
                if (best_slot < 0)
                    res.table_full = 1'b1;
                else
                begin
                    trk_valid[best_slot] = 1'b1;
                    trk_taken[best_slot] = 1'b1;
                    trk_id[best_slot]    = id_counter;
                    trk_x[best_slot]     = r.center_x;
                    trk_y[best_slot]     = r.center_y;
                    trk_area[best_slot]  = r.blob_area;
                    trk_act[best_slot]   = ACT_CAP;
                    trk_seen[best_slot]  = r.time_ms;
                    res.matched = 1'b1;
                    res.blob_id = id_counter;
                    res.activity_level = ACT_CAP;
                    id_counter = id_counter + 16'd1;
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!trk_valid[i])
                        continue;
                    if (trk_taken[i])
                        trk_seen[i] = r.time_ms;
                    else if (32'(r.time_ms - trk_seen[i]) > {16'd0, death_ms})
                        trk_valid[i] = 1'b0;
                end
                if (live_slots() == 0)
                    id_counter = 16'd0;
            end
        endcase
        res.live_count = live_slots();
        return res;
    endfunction

    // drive one request and hold it until taken
    task automatic send_req(input in_item_t r, input bit fixed, input out_item_t want);
        out_item_t pred;
        out_item_t exp_res;
        in_data  <= r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pred = track_step(r);
        exp_res = fixed ? want : pred;
        pending_results.insert(pending_results.size(), exp_res);
        if (!steady && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    endtask

    task automatic send(input in_item_t r);
        send_req(r, 1'b0, '0);
    endtask

    // write a register once the block has drained
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
        cfg_data  <= '{index: idx, data: val};
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] d, input logic [31:0] m,
                             input logic [31:0] t, input logic [31:0] k);
        write_reg(REG_DEATH, d);
        write_reg(REG_MAXD, m);
        write_reg(REG_THRESH, t);
        write_reg(REG_DECAY, k);
    endtask

    function automatic in_item_t make_req(input logic [1:0] m, input logic [11:0] x,
                                          input logic [11:0] y, input logic [19:0] ar,
                                          input logic [31:0] t);
        in_item_t r;
        r.mode = m;
        r.center_x = x;
        r.center_y = y;
        r.blob_area = ar;
        r.time_ms = t;
        return r;
    endfunction

    function automatic logic [11:0] near_coord(input logic [11:0] c, input int span);
        int v;
        v = int'(c) + $urandom_range(2 * span) - span;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[11:0];
    endfunction

    // one frame: start, matches near tracked blobs or at random points, adds, end, at times a stray request
    task automatic send_frame(inout int sent);
        int       k;
        int       pick;
        int       span;
        in_item_t r;
        send(make_req(MODE_START, 12'($urandom), 12'($urandom), 20'($urandom), $urandom));
        sent++;
        k = $urandom_range(6);
        for (int j = 0; j < k; j++)
        begin
            pick = $urandom_range(SLOTS - 1);
            span = radius / 2 + 1;
            if (trk_valid[pick] && $urandom_range(3) != 0)
                r = make_req(MODE_MATCH, near_coord(trk_x[pick], span),
                             near_coord(trk_y[pick], span), 20'($urandom), $urandom);
            else
                r = make_req(MODE_MATCH, 12'($urandom), 12'($urandom), 20'($urandom),
                             $urandom);
            send(r);
            sent++;
        end
        k = $urandom_range(3);
        for (int j = 0; j < k; j++)
        begin
            send(make_req(MODE_ADD, 12'($urandom), 12'($urandom),
                          ($urandom_range(1)) ? 20'($urandom_range(255)) : 20'($urandom),
                          now_ms));
            sent++;
        end
        if ($urandom_range(9) == 0)
            now_ms = $urandom;
        else
            now_ms = now_ms + $urandom_range(2 * int'(death_ms) + 10);
        send(make_req(MODE_END, 12'($urandom), 12'($urandom), 20'($urandom), now_ms));
        sent++;
        // stray request
        if ($urandom_range(9) == 0)
        begin
            send(in_item_t'(($bits(in_item_t))'({$urandom, $urandom, $urandom})));
            sent++;
        end
    endtask

    // check each result against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_error("result with no request outstanding");
            else
            begin
                w = pending_results.pop_front();
                if (out_data.matched !== w.matched)
                    report_error($sformatf("matched %0b want %0b", out_data.matched, w.matched));
                if (out_data.blob_id !== w.blob_id)
                    report_error($sformatf("blob_id %0d want %0d", out_data.blob_id, w.blob_id));
                if (out_data.activity_level !== w.activity_level)
                    report_error($sformatf("activity %0d want %0d",
                                           out_data.activity_level, w.activity_level));
                if (out_data.live_count !== w.live_count)
                    report_error($sformatf("live_count %0d want %0d",
                                           out_data.live_count, w.live_count));
                if (out_data.table_full !== w.table_full)
                    report_error($sformatf("table_full %0b want %0b",
                                           out_data.table_full, w.table_full));
            end
        end
    end

    // random backpressure on results
    always @(posedge clk)
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 33);

    initial
    begin
        int sent;
        clear_tracker();
        // directed rows: reset state, extremes, miss, ties, aging, time wrap
        stim_rows[0]  = '{make_req(MODE_START, 0, 0, 0, 0), 1'b1, '{0, 0, 0, 0, 0}};
        stim_rows[1]  = '{make_req(MODE_ADD, 0, 0, 0, 0), 1'b1, '{1, 0, 5120, 1, 0}};
        stim_rows[2]  = '{make_req(MODE_ADD, 4095, 4095, 20'hFFFFF, 32'hFFFFFFFF), 1'b1,
                          '{1, 1, 5120, 2, 0}};
        stim_rows[3]  = '{make_req(MODE_MATCH, 0, 0, 0, 0), 1'b1, '{0, 0, 0, 2, 0}};
        stim_rows[4]  = '{make_req(MODE_END, 0, 0, 0, 10), 1'b0, '0};
        stim_rows[5]  = '{make_req(MODE_START, 4095, 4095, 20'hFFFFF, 0), 1'b0, '0};
        stim_rows[6]  = '{make_req(MODE_MATCH, 3, 4, 0, 0), 1'b0, '0};
        stim_rows[7]  = '{make_req(MODE_MATCH, 4095, 4000, 0, 0), 1'b0, '0};
        stim_rows[8]  = '{make_req(MODE_MATCH, 2048, 2048, 0, 0), 1'b1, '{0, 0, 0, 2, 0}};
        stim_rows[9]  = '{make_req(MODE_ADD, 100, 100, 50, 20), 1'b1, '{1, 2, 5120, 3, 0}};
        stim_rows[10] = '{make_req(MODE_START, 0, 0, 0, 0), 1'b0, '0};
        stim_rows[11] = '{make_req(MODE_END, 0, 0, 0, 600), 1'b1, '{0, 0, 0, 0, 0}};
        stim_rows[12] = '{make_req(MODE_ADD, 6, 7, 1, 700), 1'b1, '{1, 0, 5120, 1, 0}};
        stim_rows[13] = '{make_req(MODE_ADD, 10, 7, 1, 700), 1'b1, '{1, 1, 5120, 2, 0}};
        stim_rows[14] = '{make_req(MODE_START, 0, 0, 0, 0), 1'b0, '0};
        stim_rows[15] = '{make_req(MODE_MATCH, 8, 7, 0, 0), 1'b0, '0};
        stim_rows[16] = '{make_req(MODE_MATCH, 8, 7, 0, 0), 1'b0, '0};
        stim_rows[17] = '{make_req(MODE_MATCH, 8, 7, 0, 0), 1'b1, '{0, 0, 0, 2, 0}};
        stim_rows[18] = '{make_req(MODE_END, 0, 0, 0, 701), 1'b0, '0};
        stim_rows[19] = '{make_req(MODE_START, 0, 0, 0, 0), 1'b0, '0};
        stim_rows[20] = '{make_req(MODE_END, 0, 0, 0, 5), 1'b1, '{0, 0, 0, 0, 0}};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_req(stim_rows[i].req, stim_rows[i].fixed, stim_rows[i].want);
        // fill the table, then overflow it
        for (int i = 0; i < SLOTS; i++)
            send(make_req(MODE_ADD, 12'($urandom), 12'($urandom), 20'($urandom), 0));
        send_req(make_req(MODE_ADD, 1, 1, 1, 0), 1'b1, '{0, 0, 0, 32, 1});

        // random frames over several register settings
        now_ms = 32'hFFFF_F000;
        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: write_all(0, 4095, 24'hFFFFFF, 0);
                2: write_all(32'hFFFF_FFFF, 1, 0, 32'hFFFF_FFFF);
                3: write_all(200, 300, 1000, 40000);
                4: write_all($urandom_range(1000), $urandom_range(400),
                             $urandom_range(5000), $urandom_range(65536));
                default: write_all(500, 100, 0, 65536);
            endcase
            steady = (phase == 3);
            while (sent < (phase + 1) * RANDOM_REQS / 5)
                send_frame(sent);
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- nearest_blob_tracker_table.f -----
sv/nbt_pkg.sv
sv/nbt_datapath.sv
sv/nbt_ctrl.sv
sv/nearest_blob_tracker_table.sv
sim/nearest_blob_tracker_table_tb.sv
